FILE: rtl/bitmap_priority_run_queue_assert.svh
// assertion macros for the run queue datapath
`ifndef BITMAP_PRIORITY_RUN_QUEUE_ASSERT_SVH
`define BITMAP_PRIORITY_RUN_QUEUE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BPRQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define BPRQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bprq_pkg.sv
package bprq_pkg;

  localparam int unsigned TASKS   = 64;
  localparam int unsigned CLASSES = 4;
  localparam int unsigned LEVELS  = 32;
  localparam int unsigned NSLOTS  = CLASSES * LEVELS;

  localparam int unsigned TW = $clog2(TASKS);
  localparam int unsigned CW = $clog2(CLASSES);
  localparam int unsigned LW = $clog2(LEVELS);
  localparam int unsigned SW = CW + LW;
  localparam int unsigned NW = $clog2(TASKS + 1);

  typedef enum logic [1:0] {
    OP_ENQ   = 2'd0,
    OP_REM   = 2'd1,
    OP_SCHED = 2'd2,
    OP_BAD   = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_REQ_SLOT,
    CMD_APP_RD,
    CMD_APP_WR,
    CMD_PICK,
    CMD_HEAD_RD,
    CMD_UNL_LINK,
    CMD_UNL_SLOT,
    CMD_UNL_WR,
    CMD_FINISH
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_REQ_SLOT,
    ST_APP_RD,
    ST_APP_WR,
    ST_PICK,
    ST_HEAD_RD,
    ST_UNL_LINK,
    ST_UNL_SLOT,
    ST_UNL_WR,
    ST_FINISH
  } st_e;

  typedef struct packed {
    cmd_e cmd;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic error;
    logic requeue;
    logic found;
  } sts_t;

endpackage

FILE: rtl/bprq_ctrl.sv
module bprq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  bprq_pkg::sts_t sts_i,
  output bprq_pkg::cmd_t cmd_o,
  output logic          busy_o
);
  import bprq_pkg::*;

  st_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o.cmd = CMD_NONE;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.cmd = CMD_LOAD;
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts_i.error) begin
          state_d = ST_FINISH;
        end else begin
          case (sts_i.op)
            OP_ENQ:   state_d = ST_APP_RD;
            OP_REM:   state_d = ST_UNL_LINK;
            OP_SCHED: state_d = sts_i.requeue ? ST_REQ_SLOT : ST_PICK;
            default:  state_d = ST_FINISH;
          endcase
        end
      end
      ST_REQ_SLOT: begin
        cmd_o.cmd = CMD_REQ_SLOT;
        state_d = ST_APP_RD;
      end
      ST_APP_RD: begin
        cmd_o.cmd = CMD_APP_RD;
        state_d = ST_APP_WR;
      end
      ST_APP_WR: begin
        cmd_o.cmd = CMD_APP_WR;
        state_d = (sts_i.op == OP_SCHED) ? ST_PICK : ST_FINISH;
      end
      ST_PICK: begin
        cmd_o.cmd = CMD_PICK;
        state_d = ST_HEAD_RD;
      end
      ST_HEAD_RD: begin
        cmd_o.cmd = CMD_HEAD_RD;
        state_d = sts_i.found ? ST_UNL_LINK : ST_FINISH;
      end
      ST_UNL_LINK: begin
        cmd_o.cmd = CMD_UNL_LINK;
        state_d = ST_UNL_SLOT;
      end
      ST_UNL_SLOT: begin
        cmd_o.cmd = CMD_UNL_SLOT;
        state_d = ST_UNL_WR;
      end
      ST_UNL_WR: begin
        cmd_o.cmd = CMD_UNL_WR;
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        cmd_o.cmd = CMD_FINISH;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

FILE: rtl/bprq_dp.sv
module bprq_dp (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  bprq_pkg::cmd_t          cmd_i,
  output bprq_pkg::sts_t          sts_o,
  input  logic [1:0]              operation_i,
  input  logic [bprq_pkg::TW-1:0] task_id_i,
  input  logic [bprq_pkg::CW-1:0] task_class_i,
  input  logic [7:0]              task_priority_i,
  input  logic                    still_runnable_i,
  output logic                    result_valid_o,
  output logic                    status_o,
  output logic [bprq_pkg::TW-1:0] running_task_o,
  output logic                    running_idle_o,
  output logic                    switched_o,
  output logic                    preempt_request_o,
  output logic [bprq_pkg::NW-1:0] ready_count_o
);
  import bprq_pkg::*;

  // memories
  logic [TW-1:0] next_mem [TASKS];
  logic [TW-1:0] prev_mem [TASKS];
  logic [SW-1:0] slot_mem [TASKS];
  logic [7:0]    prio_mem [TASKS];
  logic [TW-1:0] head_mem [NSLOTS];
  logic [TW-1:0] tail_mem [NSLOTS];
  logic [NW-1:0] cnt_mem  [NSLOTS];

  logic [TW-1:0] next_rd, prev_rd, head_rd, tail_rd;
  logic [SW-1:0] ts_rd;
  logic [7:0]    prio_rd;
  logic [NW-1:0] cnt_rd;

  logic          next_we, prev_we, slot_we, prio_we, head_we, tail_we, cnt_we;
  logic [TW-1:0] next_wa, next_wd, prev_wa, prev_wd, head_wd, tail_wd;
  logic [SW-1:0] head_wa;
  logic [NW-1:0] cnt_wd;

  // control and current-task state
  op_e           op_q, op_d;
  logic          err_q, err_d;
  logic          req_q, req_d;
  logic          pre_q, pre_d;
  logic [TW-1:0] tgt_q, tgt_d;
  logic [SW-1:0] slot_q, slot_d;
  logic [SW-1:0] app_slot_q, app_slot_d;
  logic [7:0]    prio_q, prio_d;
  logic [SW-1:0] pick_slot_q, pick_slot_d;
  logic          found_q, found_d;
  logic [TW-1:0] cur_task_q, cur_task_d;
  logic          cur_idle_q, cur_idle_d;
  logic          cur_valid_q, cur_valid_d;
  logic [7:0]    cur_prio_q, cur_prio_d;
  logic [NW-1:0] wait_q, wait_d;
  logic [CLASSES-1:0][LEVELS-1:0] lvl_q, lvl_d;
  logic [CLASSES-1:0] cbm_q, cbm_d;
  logic [TASKS-1:0]   queued_q, queued_d;

  // result registers
  logic          rv_q, rv_d;
  logic          rs_q, rsw_q, rpre_q;
  logic          rs_d, rsw_d, rpre_d;

  logic          running_real;
  logic          lvl_bit;
  logic [CW-1:0] cls_sel;
  logic [LW-1:0] lev_sel;
  logic          bm_ok;

  assign running_real = cur_valid_q && !cur_idle_q;
  assign lvl_bit      = lvl_q[slot_q[SW-1:LW]][slot_q[LW-1:0]];

  // link memories, read address follows the target task
  always_ff @(posedge clk_i) begin
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    next_rd <= next_mem[tgt_d];
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    prev_rd <= prev_mem[tgt_d];
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[tgt_q] <= slot_q;
    end
    ts_rd <= slot_mem[tgt_d];
  end

  always_ff @(posedge clk_i) begin
    if (prio_we) begin
      prio_mem[tgt_q] <= prio_q;
    end
    prio_rd <= prio_mem[tgt_d];
  end

  // per-queue memories, read address follows the slot
  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[head_wa] <= head_wd;
    end
    head_rd <= head_mem[slot_d];
  end

  always_ff @(posedge clk_i) begin
    if (tail_we) begin
      tail_mem[slot_q] <= tail_wd;
    end
    tail_rd <= tail_mem[slot_d];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[slot_q] <= cnt_wd;
    end
    cnt_rd <= cnt_mem[slot_d];
  end

  // highest nonempty class, then highest nonempty level
  always_comb begin
    cls_sel = '0;
    lev_sel = '0;
    for (int i = 0; i < CLASSES; i++) begin
      if (cbm_q[i]) begin
        cls_sel = CW'(i);
      end
    end
    for (int j = 0; j < LEVELS; j++) begin
      if (lvl_q[cls_sel][j]) begin
        lev_sel = LW'(j);
      end
    end
  end

  // datapath step logic
  always_comb begin
    op_d        = op_q;
    err_d       = err_q;
    req_d       = req_q;
    pre_d       = pre_q;
    tgt_d       = tgt_q;
    slot_d      = slot_q;
    app_slot_d  = app_slot_q;
    prio_d      = prio_q;
    pick_slot_d = pick_slot_q;
    found_d     = found_q;
    cur_task_d  = cur_task_q;
    cur_idle_d  = cur_idle_q;
    cur_valid_d = cur_valid_q;
    cur_prio_d  = cur_prio_q;
    wait_d      = wait_q;
    lvl_d       = lvl_q;
    cbm_d       = cbm_q;
    queued_d    = queued_q;
    rv_d        = 1'b0;
    rs_d        = rs_q;
    rsw_d       = rsw_q;
    rpre_d      = rpre_q;
    next_we = 1'b0; next_wa = tail_rd; next_wd = tgt_q;
    prev_we = 1'b0; prev_wa = tgt_q;   prev_wd = tail_rd;
    slot_we = 1'b0; prio_we = 1'b0;
    head_we = 1'b0; head_wa = slot_q;  head_wd = tgt_q;
    tail_we = 1'b0; tail_wd = tgt_q;
    cnt_we  = 1'b0; cnt_wd  = '0;
    case (cmd_i.cmd)
      // capture the transaction and check it
      CMD_LOAD: begin
        op_d       = op_e'(operation_i);
        tgt_d      = (op_e'(operation_i) == OP_SCHED) ? cur_task_q : task_id_i;
        app_slot_d = {task_class_i, task_priority_i[LW-1:0]};
        prio_d     = task_priority_i;
        pre_d      = 1'b0;
        req_d      = (op_e'(operation_i) == OP_SCHED) && running_real && still_runnable_i;
        case (op_e'(operation_i))
          OP_ENQ:   err_d = queued_q[task_id_i] || (running_real && cur_task_q == task_id_i);
          OP_REM:   err_d = !queued_q[task_id_i];
          OP_SCHED: err_d = 1'b0;
          default:  err_d = 1'b1;
        endcase
      end
      CMD_APP_RD: begin
        slot_d = (op_q == OP_SCHED) ? ts_rd : app_slot_q;
      end
      // append tgt_q to the tail of queue slot_q
      CMD_APP_WR: begin
        if (!lvl_bit) begin
          head_we = 1'b1;
          cnt_wd  = NW'(1);
        end else begin
          next_we = 1'b1;
          prev_we = 1'b1;
          cnt_wd  = cnt_rd + NW'(1);
        end
        tail_we = 1'b1;
        cnt_we  = 1'b1;
        slot_we = 1'b1;
        queued_d[tgt_q] = 1'b1;
        wait_d = wait_q + NW'(1);
        lvl_d[slot_q[SW-1:LW]][slot_q[LW-1:0]] = 1'b1;
        cbm_d[slot_q[SW-1:LW]] = 1'b1;
        if (op_q == OP_ENQ) begin
          prio_we = 1'b1;
          pre_d = cur_valid_q && (prio_q > (cur_idle_q ? 8'd0 : cur_prio_q));
        end
      end
      CMD_PICK: begin
        found_d     = |cbm_q;
        pick_slot_d = {cls_sel, lev_sel};
      end
      CMD_HEAD_RD: begin
        slot_d = pick_slot_q;
      end
      CMD_UNL_LINK: begin
        if (op_q == OP_SCHED) begin
          tgt_d = head_rd;
        end
      end
      CMD_UNL_SLOT: begin
        slot_d = ts_rd;
      end
      // unlink tgt_q from queue slot_q
      CMD_UNL_WR: begin
        cnt_we = 1'b1;
        if (cnt_rd <= NW'(1)) begin
          cnt_wd = '0;
          lvl_d[slot_q[SW-1:LW]][slot_q[LW-1:0]] = 1'b0;
          if (lvl_d[slot_q[SW-1:LW]] == '0) begin
            cbm_d[slot_q[SW-1:LW]] = 1'b0;
          end
        end else begin
          cnt_wd = cnt_rd - NW'(1);
          if (head_rd == tgt_q) begin
            head_we = 1'b1;
            head_wd = next_rd;
          end else if (tail_rd == tgt_q) begin
            tail_we = 1'b1;
            tail_wd = prev_rd;
          end else begin
            next_we = 1'b1;
            next_wa = prev_rd;
            next_wd = next_rd;
            prev_we = 1'b1;
            prev_wa = next_rd;
            prev_wd = prev_rd;
          end
        end
        queued_d[tgt_q] = 1'b0;
        if (wait_q != '0) begin
          wait_d = wait_q - NW'(1);
        end
      end
      // commit the current task and present the result
      CMD_FINISH: begin
        rv_d   = 1'b1;
        rs_d   = err_q;
        rpre_d = (op_q == OP_ENQ) && !err_q && pre_q;
        rsw_d  = 1'b0;
        if (op_q == OP_SCHED) begin
          cur_valid_d = 1'b1;
          if (found_q) begin
            cur_idle_d = 1'b0;
            cur_task_d = tgt_q;
            cur_prio_d = prio_rd;
          end else begin
            cur_idle_d = 1'b1;
            cur_task_d = '0;
          end
          rsw_d = !cur_valid_q || (cur_idle_q != cur_idle_d) ||
                  (!cur_idle_q && cur_task_q != cur_task_d);
        end
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_task_q  <= '0;
      cur_idle_q  <= 1'b1;
      cur_valid_q <= 1'b0;
      wait_q      <= '0;
      lvl_q       <= '0;
      cbm_q       <= '0;
      queued_q    <= '0;
      rv_q        <= 1'b0;
      op_q        <= OP_ENQ;
      err_q       <= 1'b0;
      req_q       <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      cur_task_q  <= cur_task_d;
      cur_idle_q  <= cur_idle_d;
      cur_valid_q <= cur_valid_d;
      wait_q      <= wait_d;
      lvl_q       <= lvl_d;
      cbm_q       <= cbm_d;
      queued_q    <= queued_d;
      rv_q        <= rv_d;
      op_q        <= op_d;
      err_q       <= err_d;
      req_q       <= req_d;
      found_q     <= found_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pre_q       <= pre_d;
    tgt_q       <= tgt_d;
    slot_q      <= slot_d;
    app_slot_q  <= app_slot_d;
    prio_q      <= prio_d;
    pick_slot_q <= pick_slot_d;
    cur_prio_q  <= cur_prio_d;
    rs_q        <= rs_d;
    rsw_q       <= rsw_d;
    rpre_q      <= rpre_d;
  end

  assign sts_o.op      = op_q;
  assign sts_o.error   = err_q;
  assign sts_o.requeue = req_q;
  assign sts_o.found   = found_q;

  assign result_valid_o    = rv_q;
  assign status_o          = rs_q;
  assign running_task_o    = cur_task_q;
  assign running_idle_o    = cur_idle_q;
  assign switched_o        = rsw_q;
  assign preempt_request_o = rpre_q;
  assign ready_count_o     = wait_q;

  // class bitmap mirrors nonempty level bitmaps
  always_comb begin
    bm_ok = 1'b1;
    for (int k = 0; k < CLASSES; k++) begin
      if (cbm_q[k] != (|lvl_q[k])) begin
        bm_ok = 1'b0;
      end
    end
  end

`include "bitmap_priority_run_queue_assert.svh"

  `BPRQ_ASSERT_NOW(a_bitmap_sync, 1'b1, bm_ok, "class bitmap out of step with level bitmaps")
  `BPRQ_ASSERT_NOW(a_count_range, 1'b1, wait_q <= NW'(TASKS), "ready count above task total")
  `BPRQ_ASSERT_NEXT(a_strobe_pulse, rv_q, !rv_q, "result strobe longer than one cycle")
  `BPRQ_ASSERT_NOW(a_idle_zero, cur_idle_q, cur_task_q == '0, "idle with nonzero task")

endmodule

FILE: rtl/bitmap_priority_run_queue.sv
// throughput: one transaction at a time; busy stays high until the result strobe cycle
// the step sequencer with single-port reads of the link and queue memories sets the rate
// results are strobed for one cycle on result_valid_o; the receiver cannot stall
// reset (rst_ni low, asynchronous): queues empty, idle task current, no current task yet
module bitmap_priority_run_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              operation_i,
  input  logic [bprq_pkg::TW-1:0] task_id_i,
  input  logic [bprq_pkg::CW-1:0] task_class_i,
  input  logic [7:0]              task_priority_i,
  input  logic                    still_runnable_i,
  output logic                    result_valid_o,
  output logic                    status_o,
  output logic [bprq_pkg::TW-1:0] running_task_o,
  output logic                    running_idle_o,
  output logic                    switched_o,
  output logic                    preempt_request_o,
  output logic [bprq_pkg::NW-1:0] ready_count_o
);
  import bprq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // step sequencer
  bprq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  // queue memories, bitmaps and current task
  bprq_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .operation_i       (operation_i),
    .task_id_i         (task_id_i),
    .task_class_i      (task_class_i),
    .task_priority_i   (task_priority_i),
    .still_runnable_i  (still_runnable_i),
    .result_valid_o    (result_valid_o),
    .status_o          (status_o),
    .running_task_o    (running_task_o),
    .running_idle_o    (running_idle_o),
    .switched_o        (switched_o),
    .preempt_request_o (preempt_request_o),
    .ready_count_o     (ready_count_o)
  );

endmodule

FILE: sim/bitmap_priority_run_queue_tb.sv
module bitmap_priority_run_queue_tb;
  import bprq_pkg::*;

  typedef struct packed {
    op_e        op;
    logic [5:0] tid;
    logic [1:0] cls;
    logic [7:0] prio;
    logic       runnable;
  } sched_req_t;

  typedef struct packed {
    logic       status;
    logic [5:0] task_id;
    logic       idle;
    logic       switched;
    logic       preempt;
    logic [6:0] ready;
  } sched_rsp_t;

  localparam int unsigned MAX_CYCLES = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] operation_i = '0;
  logic [5:0] task_id_i = '0;
  logic [1:0] task_class_i = '0;
  logic [7:0] task_priority_i = '0;
  logic still_runnable_i = 1'b0;
  logic result_valid_o, status_o, running_idle_o, switched_o, preempt_request_o;
  logic [5:0] running_task_o;
  logic [6:0] ready_count_o;

  sched_req_t pending_reqs[$];
  sched_rsp_t expected_rsps[$];
  int unsigned fail_count = 0;
  int unsigned rsp_count = 0;
  int unsigned cycle_count = 0;
  int unsigned sched_count = 0;
  bit calm_stretch = 1'b0;

  // predictor copy of the run queue
  logic [5:0] nxt_q[TASKS];
  logic [5:0] prv_q[TASKS];
  logic [5:0] head_q[NSLOTS];
  logic [5:0] tail_q[NSLOTS];
  int unsigned cnt_q[NSLOTS];
  logic [31:0] lvl_map[CLASSES];
  logic [3:0] cls_map;
  logic [6:0] slot_of[TASKS];
  logic [7:0] prio_of[TASKS];
  bit queued[TASKS];
  logic [5:0] cur_task;
  bit cur_idle, cur_valid;
  int unsigned waiting;

  always #10 clk_i = ~clk_i;

  bitmap_priority_run_queue DUT (.*);

  function automatic void rq_append(int unsigned t, int unsigned slot);
    if (cnt_q[slot] == 0) head_q[slot] = 6'(t);
    else begin
      nxt_q[tail_q[slot]] = 6'(t);
      prv_q[t] = tail_q[slot];
    end
    tail_q[slot] = 6'(t);
    cnt_q[slot]++;
    slot_of[t] = 7'(slot);
    queued[t] = 1'b1;
    waiting++;
    lvl_map[slot / LEVELS][slot % LEVELS] = 1'b1;
    cls_map[slot / LEVELS] = 1'b1;
  endfunction

  function automatic void rq_unlink(int unsigned t);
    int unsigned slot;
    slot = 32'(slot_of[t]);
    if (cnt_q[slot] <= 1) cnt_q[slot] = 0;
    else begin
      if (head_q[slot] == t) head_q[slot] = nxt_q[t];
      else if (tail_q[slot] == t) tail_q[slot] = prv_q[t];
      else begin
        nxt_q[prv_q[t]] = nxt_q[t];
        prv_q[nxt_q[t]] = prv_q[t];
      end
      cnt_q[slot]--;
    end
    queued[t] = 1'b0;
    if (waiting > 0) waiting--;
    if (cnt_q[slot] == 0) begin
      lvl_map[slot / LEVELS][slot % LEVELS] = 1'b0;
      if (lvl_map[slot / LEVELS] == 0) cls_map[slot / LEVELS] = 1'b0;
    end
  endfunction

  // expected result of one transaction, updating the predictor state
  function automatic sched_rsp_t rq_predict(sched_req_t r);
    sched_rsp_t e;
    bit real_run, p_valid, p_idle;
    logic [5:0] p_task;
    int slot;
    e = '0;
    real_run = cur_valid && !cur_idle;
    case (r.op)
      OP_ENQ: begin
        if (queued[r.tid] || (real_run && cur_task == r.tid)) e.status = 1'b1;
        else begin
          prio_of[r.tid] = r.prio;
          rq_append(32'(r.tid), 32'(r.cls) * LEVELS + 32'(r.prio) % LEVELS);
          if (cur_valid) e.preempt = r.prio > (cur_idle ? 8'd0 : prio_of[cur_task]);
        end
      end
      OP_REM: begin
        if (!queued[r.tid]) e.status = 1'b1;
        else rq_unlink(32'(r.tid));
      end
      OP_SCHED: begin
        p_valid = cur_valid; p_idle = cur_idle; p_task = cur_task;
        if (real_run && r.runnable) rq_append(32'(cur_task), 32'(slot_of[cur_task]));
        slot = -1;
        for (int c = CLASSES - 1; c >= 0 && slot < 0; c--)
          if (cls_map[c])
            for (int l = LEVELS - 1; l >= 0 && slot < 0; l--)
              if (lvl_map[c][l]) slot = c * LEVELS + l;
        if (slot < 0) begin
          cur_idle = 1'b1; cur_task = '0;
        end else begin
          cur_task = head_q[slot];
          rq_unlink(32'(cur_task));
          cur_idle = 1'b0;
        end
        cur_valid = 1'b1;
        e.switched = !p_valid || p_idle != cur_idle || (!p_idle && p_task != cur_task);
      end
      default: e.status = 1'b1;
    endcase
    e.task_id = cur_task;
    e.idle = cur_idle;
    e.ready = 7'(waiting);
    return e;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch at transaction %0d: %s got %0d expected %0d", rsp_count, what, got,
             want);
    fail_count++;
  endtask

  function automatic sched_req_t mk(op_e op, int unsigned tid, int unsigned cls,
                                    int unsigned prio, bit run);
    sched_req_t r;
    r.op = op; r.tid = 6'(tid); r.cls = 2'(cls); r.prio = 8'(prio); r.runnable = run;
    return r;
  endfunction

  // driver: issue one pending transaction when not busy
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        expected_rsps.push_back(rq_predict(pending_reqs.pop_front()));
        calm_stretch = (sched_count >= 240 && sched_count < 360);
        sched_count++;
      end
      if (!(start && busy)) begin
        if (pending_reqs.size() > 0 && (calm_stretch || $urandom_range(0, 99) >= 32)) begin
          start <= 1'b1;
          operation_i <= pending_reqs[0].op;
          task_id_i <= pending_reqs[0].tid;
          task_class_i <= pending_reqs[0].cls;
          task_priority_i <= pending_reqs[0].prio;
          still_runnable_i <= pending_reqs[0].runnable;
        end else start <= 1'b0;
      end
    end
  end

  // monitor: compare each strobed result with the oldest expectation
  always @(posedge clk_i) begin
    cycle_count++;
    if (rst_ni && result_valid_o) begin
      if (expected_rsps.size() == 0) begin
        $display("unexpected result at cycle %0d", cycle_count);
        fail_count++;
      end else begin
        sched_rsp_t e;
        e = expected_rsps.pop_front();
        if (status_o !== e.status)
          report_mismatch("status", 32'(status_o), 32'(e.status));
        if (running_task_o !== e.task_id)
          report_mismatch("running_task", 32'(running_task_o), 32'(e.task_id));
        if (running_idle_o !== e.idle)
          report_mismatch("running_idle", 32'(running_idle_o), 32'(e.idle));
        if (switched_o !== e.switched)
          report_mismatch("switched", 32'(switched_o), 32'(e.switched));
        if (preempt_request_o !== e.preempt)
          report_mismatch("preempt_request", 32'(preempt_request_o), 32'(e.preempt));
        if (ready_count_o !== e.ready)
          report_mismatch("ready_count", 32'(ready_count_o), 32'(e.ready));
      end
      rsp_count++;
    end
  end

  // timeout
  always @(posedge clk_i) begin
    if (cycle_count > MAX_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int unsigned pick;
    cur_task = '0; cur_idle = 1'b1; cur_valid = 1'b0; waiting = 0; cls_map = '0;
    for (int i = 0; i < CLASSES; i++) lvl_map[i] = '0;
    for (int i = 0; i < NSLOTS; i++) cnt_q[i] = 0;
    for (int i = 0; i < TASKS; i++) queued[i] = 1'b0;

    // directed: preempt before first schedule, extremes, errors, idle paths
    pending_reqs.push_back(mk(OP_ENQ, 0, 0, 0, 0));
    pending_reqs.push_back(mk(OP_ENQ, 63, 3, 255, 1));
    pending_reqs.push_back(mk(OP_ENQ, 63, 1, 5, 0));
    pending_reqs.push_back(mk(OP_BAD, 21, 2, 170, 1));
    pending_reqs.push_back(mk(OP_SCHED, 42, 1, 85, 1));
    pending_reqs.push_back(mk(OP_ENQ, 63, 0, 1, 0));
    pending_reqs.push_back(mk(OP_REM, 63, 0, 0, 0));
    pending_reqs.push_back(mk(OP_ENQ, 10, 3, 31, 0));
    pending_reqs.push_back(mk(OP_ENQ, 11, 3, 63, 0));
    pending_reqs.push_back(mk(OP_ENQ, 12, 3, 95, 0));
    pending_reqs.push_back(mk(OP_REM, 11, 0, 0, 0));
    pending_reqs.push_back(mk(OP_SCHED, 0, 0, 0, 1));
    pending_reqs.push_back(mk(OP_SCHED, 0, 0, 0, 0));
    pending_reqs.push_back(mk(OP_SCHED, 0, 0, 0, 1));
    pending_reqs.push_back(mk(OP_SCHED, 0, 0, 0, 1));
    pending_reqs.push_back(mk(OP_SCHED, 0, 0, 0, 1));
    pending_reqs.push_back(mk(OP_ENQ, 5, 2, 128, 0));
    pending_reqs.push_back(mk(OP_REM, 5, 0, 0, 0));
    pending_reqs.push_back(mk(OP_REM, 5, 0, 0, 0));
    pending_reqs.push_back(mk(OP_SCHED, 0, 0, 0, 1));

    // random: mostly enqueues and schedules over a small task pool, some noise
    for (int i = 0; i < 650; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45)
        pending_reqs.push_back(mk(OP_ENQ, $urandom_range(0, 1) ? $urandom_range(0, 15)
                                  : $urandom_range(0, 63), $urandom_range(0, 3),
                                  $urandom_range(0, 255), 1'b0));
      else if (pick < 65)
        pending_reqs.push_back(mk(OP_REM, $urandom_range(0, 1) ? $urandom_range(0, 15)
                                  : $urandom_range(0, 63), $urandom, $urandom,
                                  $urandom_range(0, 1) != 0));
      else if (pick < 97)
        pending_reqs.push_back(mk(OP_SCHED, $urandom, $urandom, $urandom,
                                  $urandom_range(0, 3) != 0));
      else
        pending_reqs.push_back(mk(OP_BAD, $urandom, $urandom, $urandom,
                                  $urandom_range(0, 1) != 0));
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_reqs.size() == 0 && !start);
    wait (expected_rsps.size() == 0);
    repeat (20) @(posedge clk_i);
    $display("ran %0d transactions: enqueue, remove, schedule and bad operations", rsp_count);
    $display("with random issue gaps and idle, requeue and error cases");
    if (fail_count == 0 && expected_rsps.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: bitmap_priority_run_queue.f
+incdir+rtl
rtl/bprq_pkg.sv
rtl/bprq_ctrl.sv
rtl/bprq_dp.sv
rtl/bitmap_priority_run_queue.sv
sim/bitmap_priority_run_queue_tb.sv
